FILE: rtl/scba_pkg.sv
// Package for the size-class block allocator: request/response structs,
// mode and status codes, the size-class table and default parameter values.
// No dependencies.
package scba_pkg;

  localparam int ADDR_W      = 20;
  localparam int SIZE_W      = 16;
  localparam int SLOT_W      = 16;
  localparam int LINK_W      = SLOT_W + 1;
  localparam int CLASS_TOTAL = 14;
  localparam int CLS_BYTES_W = 10;
  localparam int CLS_SEL_W   = 4;

  localparam int DEF_CHUNK_BYTES     = 16384;
  localparam int DEF_NUM_CHUNKS      = 64;
  localparam int DEF_MAX_BLOCK_BYTES = 640;
  localparam int DEF_SIZE_CLASSES    = 14;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_IGNORED   = 2'd1;
  localparam logic [1:0] ST_OVERSIZE  = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  // Bit 16 set marks an empty list / end of list.
  localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {SLOT_W{1'b0}}};

  typedef struct packed {
    logic [1:0]        mode;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
    logic              address_is_null;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
  } rsp_t;

  function automatic logic [CLS_BYTES_W-1:0] class_bytes(input logic [CLS_SEL_W-1:0] idx);
    logic [CLS_BYTES_W-1:0] b;
    case (idx)
      4'd0:    b = 10'd16;
      4'd1:    b = 10'd32;
      4'd2:    b = 10'd64;
      4'd3:    b = 10'd96;
      4'd4:    b = 10'd128;
      4'd5:    b = 10'd160;
      4'd6:    b = 10'd192;
      4'd7:    b = 10'd224;
      4'd8:    b = 10'd256;
      4'd9:    b = 10'd320;
      4'd10:   b = 10'd384;
      4'd11:   b = 10'd448;
      4'd12:   b = 10'd512;
      4'd13:   b = 10'd640;
      default: b = 10'd640;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/size_class_block_allocator_core.sv
// Size-class block allocator core: free-list heads, chunk carving sequencer
// and the link memory. Depends on scba_pkg.
//
// One request is taken when start is high and busy is low; exactly one response
// follows as a one-cycle out_valid pulse, which the receiver cannot stall.
// Free, clear, ignored and rejected requests are answered by the decode state;
// an allocation popped from a free list is answered by the pop state, after the
// registered read of the link memory. An allocation that carves a fresh chunk
// runs one shared add-and-compare step per block, writing one link per cycle,
// and answers once the link of the last block that fits is written. busy stays
// high from the accepted request until the response cycle, in which the next
// request may already be taken. The link memory is never cleared; links are
// always written before they are followed.
module size_class_block_allocator_core #(
  parameter int CHUNK_BYTES     = scba_pkg::DEF_CHUNK_BYTES,
  parameter int NUM_CHUNKS      = scba_pkg::DEF_NUM_CHUNKS,
  parameter int MAX_BLOCK_BYTES = scba_pkg::DEF_MAX_BLOCK_BYTES,
  parameter int SIZE_CLASSES    = scba_pkg::DEF_SIZE_CLASSES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  scba_pkg::req_t in_req,
  output logic           out_valid,
  output scba_pkg::rsp_t out_rsp
);
  import scba_pkg::*;

  localparam int CLS_W     = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int CNT_W     = $clog2(NUM_CHUNKS + 1);
  localparam int OFF_W     = $clog2(CHUNK_BYTES) + 2;
  localparam int LINK_DEPTH = 1 << SLOT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_POP    = 2'd2;
  localparam logic [1:0] S_CARVE  = 2'd3;

  logic [1:0]              state_r, state_nxt;
  req_t                    req_r;
  logic [LINK_W-1:0]       heads_r [SIZE_CLASSES];
  logic [CNT_W-1:0]        chunks_r;
  logic [ADDR_W-1:0]       base_r;
  logic [CLS_W-1:0]        cls_r;
  logic [OFF_W-1:0]        off_r;
  logic [OFF_W-1:0]        nxt_r;
  logic                    out_valid_r;
  rsp_t                    out_rsp_r;

  logic [LINK_W-1:0]       link_mem [LINK_DEPTH];
  logic [LINK_W-1:0]       rd_data_r;
  logic [SLOT_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [SLOT_W-1:0]       wr_addr;
  logic [LINK_W-1:0]       wr_data;

  logic                    cls_hit;
  logic [CLS_W-1:0]        cls_idx;
  logic [CLS_W-1:0]        cls_sel;
  logic [CLS_BYTES_W-1:0]  bsz;
  logic [OFF_W-1:0]        nxt2;
  logic                    carve_last;
  logic [ADDR_W-1:0]       cur_addr;
  logic [ADDR_W-1:0]       nxt_addr;
  logic [ADDR_W-1:0]       first_nxt_addr;
  logic                    two_fit;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Smallest configured class that holds the request size.
  always_comb begin
    cls_hit = 1'b0;
    cls_idx = '0;
    for (int c = SIZE_CLASSES - 1; c >= 0; c--) begin
      if (req_r.request_size <= SIZE_W'(class_bytes(CLS_SEL_W'(c)))) begin
        cls_hit = 1'b1;
        cls_idx = CLS_W'(c);
      end
    end
    if (req_r.request_size > SIZE_W'(MAX_BLOCK_BYTES)) begin
      cls_hit = 1'b0;
    end
  end

  // Shared add/compare unit: serves both carve setup and each carve step.
  assign cls_sel        = (state_r == S_CARVE) ? cls_r : cls_idx;
  assign bsz            = class_bytes(CLS_SEL_W'(cls_sel));
  assign nxt2           = nxt_r + OFF_W'(bsz);
  assign carve_last     = (nxt2 > OFF_W'(CHUNK_BYTES));
  assign cur_addr       = base_r + ADDR_W'(off_r);
  assign nxt_addr       = base_r + ADDR_W'(nxt_r);
  assign first_nxt_addr = base_r + ADDR_W'(bsz);
  assign two_fit        = ((OFF_W'(bsz) << 1) <= OFF_W'(CHUNK_BYTES));

  assign rd_addr = heads_r[cls_idx][SLOT_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = req_r.block_address[ADDR_W-1:4];
    wr_data = heads_r[cls_idx];
    if (state_r == S_DECODE && req_r.mode == MODE_FREE && req_r.request_size != '0
        && !req_r.address_is_null && cls_hit) begin
      wr_en = 1'b1;
    end else if (state_r == S_CARVE) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr[ADDR_W-1:4];
      wr_data = carve_last ? LINK_NULL : {1'b0, nxt_addr[ADDR_W-1:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= link_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (req_r.mode == MODE_ALLOC && req_r.request_size != '0 && cls_hit) begin
          if (!heads_r[cls_idx][SLOT_W]) begin
            state_nxt = S_POP;
          end else if (chunks_r < CNT_W'(NUM_CHUNKS)) begin
            state_nxt = S_CARVE;
          end
        end
      end
      S_POP:    state_nxt = S_IDLE;
      S_CARVE:  if (carve_last) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chunks_r    <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < SIZE_CLASSES; c++) begin
        heads_r[c] <= LINK_NULL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r <= in_req;
          end
        end
        S_DECODE: begin
          out_rsp_r.result_address <= '0;
          out_rsp_r.status         <= ST_DONE;
          cls_r                    <= cls_idx;
          unique case (req_r.mode)
            MODE_ALLOC: begin
              if (req_r.request_size == '0) begin
                out_valid_r      <= 1'b1;
                out_rsp_r.status <= ST_IGNORED;
              end else if (!cls_hit) begin
                out_valid_r      <= 1'b1;
                out_rsp_r.status <= ST_OVERSIZE;
              end else if (!heads_r[cls_idx][SLOT_W]) begin
                out_rsp_r.result_address <= {heads_r[cls_idx][SLOT_W-1:0], 4'b0000};
              end else if (chunks_r >= CNT_W'(NUM_CHUNKS)) begin
                out_valid_r      <= 1'b1;
                out_rsp_r.status <= ST_EXHAUSTED;
              end else begin
                // Block zero goes out; the list starts at block one.
                out_rsp_r.result_address <= base_r;
                heads_r[cls_idx] <= two_fit ? {1'b0, first_nxt_addr[ADDR_W-1:4]}
                                            : LINK_NULL;
                off_r <= '0;
                nxt_r <= OFF_W'(bsz);
              end
            end
            MODE_FREE: begin
              out_valid_r <= 1'b1;
              if (req_r.request_size == '0 || req_r.address_is_null) begin
                out_rsp_r.status <= ST_IGNORED;
              end else if (!cls_hit) begin
                out_rsp_r.status <= ST_OVERSIZE;
              end else begin
                heads_r[cls_idx] <= {1'b0, req_r.block_address[ADDR_W-1:4]};
              end
            end
            MODE_CLEAR: begin
              out_valid_r <= 1'b1;
              chunks_r    <= '0;
              base_r      <= '0;
              for (int c = 0; c < SIZE_CLASSES; c++) begin
                heads_r[c] <= LINK_NULL;
              end
            end
            default: begin
              out_valid_r      <= 1'b1;
              out_rsp_r.status <= ST_IGNORED;
            end
          endcase
        end
        S_POP: begin
          heads_r[cls_r] <= rd_data_r;
          out_valid_r    <= 1'b1;
        end
        S_CARVE: begin
          off_r <= nxt_r;
          nxt_r <= nxt2;
          if (carve_last) begin
            chunks_r    <= chunks_r + CNT_W'(1);
            base_r      <= base_r + ADDR_W'(CHUNK_BYTES);
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // A response only ever closes a request that was in flight.
  a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_DECODE || $past(state_r) == S_POP
                   || $past(state_r) == S_CARVE))
    else $error("response without a request in flight");

  a_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("response while sequencer still busy");

  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chunks_r <= CNT_W'(NUM_CHUNKS))
    else $error("chunk count beyond pool");

  a_status_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != ST_DONE) |-> (out_rsp.result_address == '0))
    else $error("failed request returned an address");

  a_carve_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CARVE && !carve_last) |=> (state_r == S_CARVE && off_r == $past(nxt_r)))
    else $error("carve sequence broke before last block");

endmodule

FILE: sim/size_class_block_allocator_core_test.sv
// Self-checking testbench for size_class_block_allocator_core: a directed request table with expected responses,
// then random allocate/free/clear traffic checked against a behavioral allocator model.
// Depends on scba_pkg and the core RTL.
module size_class_block_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scba_pkg::*;

  localparam int CHUNK_BYTES     = DEF_CHUNK_BYTES;
  localparam int NUM_CHUNKS      = DEF_NUM_CHUNKS;
  localparam int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES;
  localparam int SIZE_CLASSES    = DEF_SIZE_CLASSES;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int ITEM_TARGET = 1950;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t want;
  } plan_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_block_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  rsp_t out_rsp;

  // allocator model state
  logic [LINK_W-1:0] head_of [CLASS_TOTAL];
  logic [LINK_W-1:0] link_mem [1<<SLOT_W];
  int unsigned chunks_carved;
  int unsigned class_limit [CLASS_TOTAL] =
    '{16, 32, 64, 96, 128, 160, 192, 224, 256, 320, 384, 448, 512, 640};

  rsp_t expected_grants [$];
  live_block_t live_blocks [$];
  plan_row_t plan [$];
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned items_sent = 0;
  bit saw_exhausted = 1'b0;

  size_class_block_allocator_core #(
    .CHUNK_BYTES(CHUNK_BYTES),
    .NUM_CHUNKS(NUM_CHUNKS),
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
    .SIZE_CLASSES(SIZE_CLASSES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_rsp(out_rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int size_class_of(logic [SIZE_W-1:0] sz);
    if (sz > MAX_BLOCK_BYTES) return -1;
    for (int c = 0; c < SIZE_CLASSES; c++)
      if (sz <= class_limit[c]) return c;
    return -1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(logic [31:0] a);
    return a[19:4];
  endfunction

  function automatic void empty_lists();
    for (int c = 0; c < CLASS_TOTAL; c++) head_of[c] = LINK_NULL;
    chunks_carved = 0;
  endfunction

  task automatic compute_grant(input req_t r, output rsp_t g);
    int c;
    logic [SLOT_W-1:0] s;
    logic [31:0] base, bsz, cnt, i;
    g = '0;
    g.status = ST_DONE;
    case (r.mode)
      MODE_ALLOC: begin
        c = size_class_of(r.request_size);
        if (r.request_size == 0) begin
          g.status = ST_IGNORED;
        end else if (c < 0) begin
          g.status = ST_OVERSIZE;
        end else if (!head_of[c][SLOT_W]) begin
          s = head_of[c][SLOT_W-1:0];
          g.result_address = {s, 4'b0000};
          head_of[c] = link_mem[s];
        end else if (chunks_carved >= NUM_CHUNKS) begin
          g.status = ST_EXHAUSTED;
        end else begin
          // carve the next chunk, links in ascending address order
          bsz = class_limit[c];
          base = chunks_carved * CHUNK_BYTES;
          cnt = CHUNK_BYTES / bsz;
          for (i = 0; i + 1 < cnt; i++)
            link_mem[slot_of(base + bsz * i)] = {1'b0, slot_of(base + bsz * (i + 1))};
          if (cnt > 0) link_mem[slot_of(base + bsz * (cnt - 1))] = LINK_NULL;
          head_of[c] = (cnt > 1) ? {1'b0, slot_of(base + bsz)} : LINK_NULL;
          chunks_carved++;
          g.result_address = base[ADDR_W-1:0];
        end
      end
      MODE_FREE: begin
        c = size_class_of(r.request_size);
        if (r.request_size == 0 || r.address_is_null) begin
          g.status = ST_IGNORED;
        end else if (c < 0) begin
          g.status = ST_OVERSIZE;
        end else begin
          s = r.block_address[ADDR_W-1:4];
          link_mem[s] = head_of[c];
          head_of[c] = {1'b0, s};
        end
      end
      MODE_CLEAR: empty_lists();
      default: g.status = ST_IGNORED;
    endcase
  endtask

  function automatic req_t make_req(logic [1:0] m, logic [SIZE_W-1:0] sz,
                                    logic [ADDR_W-1:0] a, logic nul);
    req_t r;
    r.mode = m;
    r.request_size = sz;
    r.block_address = a;
    r.address_is_null = nul;
    return r;
  endfunction

  function automatic void add_row(req_t r, logic typed, logic [ADDR_W-1:0] want_addr,
                                  logic [1:0] want_status);
    plan_row_t row;
    row.req = r;
    row.typed = typed;
    row.want.result_address = want_addr;
    row.want.status = want_status;
    plan.push_back(row);
  endfunction

  function automatic req_t random_req();
    return make_req(2'($urandom_range(3)), SIZE_W'($urandom_range(65535)),
                    ADDR_W'($urandom_range(1048575)), 1'($urandom_range(1)));
  endfunction

  function automatic logic [SIZE_W-1:0] size_in_class(int c);
    int unsigned lo, hi;
    lo = (c == 0) ? 1 : class_limit[c-1] + 1;
    hi = class_limit[c];
    case ($urandom_range(3))
      0: return SIZE_W'(lo);
      1: return SIZE_W'(hi);
      default: return SIZE_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic req_t gen_alloc();
    req_t r;
    int roll;
    r = random_req();
    r.mode = MODE_ALLOC;
    roll = $urandom_range(99);
    if (roll < 80) r.request_size = size_in_class($urandom_range(CLASS_TOTAL - 1));
    else if (roll < 88) r.request_size = SIZE_W'($urandom_range(MAX_BLOCK_BYTES, 1));
    else if (roll < 94) r.request_size = '0;
    else r.request_size = SIZE_W'($urandom_range(65535, MAX_BLOCK_BYTES + 1));
    return r;
  endfunction

  // Return a live block most of the time; otherwise push a foreign address.
  function automatic req_t gen_free();
    req_t r;
    live_block_t b;
    int idx;
    r = random_req();
    r.mode = MODE_FREE;
    r.address_is_null = 1'b0;
    if (live_blocks.size() != 0 && $urandom_range(99) < 85) begin
      idx = $urandom_range(live_blocks.size() - 1);
      b = live_blocks[idx];
      live_blocks.delete(idx);
      r.request_size = size_in_class(size_class_of(b.size));
      r.block_address = b.addr;
      if ($urandom_range(99) < 20) r.block_address[3:0] = 4'($urandom_range(15));
    end else if ($urandom_range(99) < 85) begin
      r.request_size = SIZE_W'($urandom_range(MAX_BLOCK_BYTES, 1));
    end else begin
      r.request_size = SIZE_W'($urandom_range(65535, MAX_BLOCK_BYTES + 1));
    end
    return r;
  endfunction

  function automatic req_t gen_mixed();
    req_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) begin
      r = gen_alloc();
    end else if (roll < 90) begin
      r = gen_free();
    end else if (roll < 92) begin
      r = random_req();
      r.mode = MODE_CLEAR;
    end else if (roll < 95) begin
      r = random_req();
      r.mode = MODE_UNUSED;
    end else begin
      r = random_req();
      r.mode = $urandom_range(1) ? MODE_ALLOC : MODE_FREE;
      if (r.mode == MODE_FREE && $urandom_range(1)) begin
        r.address_is_null = 1'b1;
        r.request_size = SIZE_W'($urandom_range(65535, 1));
      end else begin
        r.request_size = '0;
      end
    end
    return r;
  endfunction

  // One carve of every smaller class, then drain the largest class, with occasional frees, until the pool runs out.
  function automatic req_t gen_fill(int step);
    req_t r;
    if (step >= CLASS_TOTAL - 1 && $urandom_range(99) < 8) return gen_free();
    r = random_req();
    r.mode = MODE_ALLOC;
    r.request_size = size_in_class(step < CLASS_TOTAL - 1 ? step : CLASS_TOTAL - 1);
    return r;
  endfunction

  task automatic pace(input bit drain);
    int gap;
    gap = 0;
    if ((items_sent < 600 || items_sent >= 900) && $urandom_range(99) < 27)
      gap = $urandom_range(6, 1);
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      start <= 1'b0;
      in_req <= random_req();
      repeat (gap) @(posedge clk);
      while (drain && expected_grants.size() != 0) @(posedge clk);
    end
  endtask

  task automatic issue(input req_t r, input logic typed, input rsp_t want);
    rsp_t got;
    live_block_t b;
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    compute_grant(r, got);
    expected_grants.push_back(typed ? want : got);
    if (r.mode == MODE_ALLOC && got.status == ST_DONE) begin
      b.addr = got.result_address;
      b.size = r.request_size;
      live_blocks.push_back(b);
    end
    if (r.mode == MODE_ALLOC && got.status == ST_EXHAUSTED) saw_exhausted = 1'b1;
    if (r.mode == MODE_CLEAR) live_blocks.delete();
    items_sent++;
  endtask

  function automatic void build_plan();
    add_row(make_req(MODE_ALLOC, 16'd0, 20'h00000, 1'b0), 1, 20'd0, ST_IGNORED);
    add_row(make_req(MODE_ALLOC, 16'hFFFF, 20'hFFFFF, 1'b1), 1, 20'd0, ST_OVERSIZE);
    add_row(make_req(MODE_ALLOC, 16'd641, 20'h00000, 1'b0), 1, 20'd0, ST_OVERSIZE);
    add_row(make_req(MODE_ALLOC, 16'd1, 20'h00000, 1'b0), 1, 20'd0, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd16, 20'h00000, 1'b0), 1, 20'd16, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd17, 20'h00000, 1'b0), 1, 20'd16384, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd640, 20'h00000, 1'b0), 1, 20'd32768, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd513, 20'h00000, 1'b0), 1, 20'd33408, ST_DONE);
    add_row(make_req(MODE_FREE, 16'd0, 20'h00005, 1'b0), 1, 20'd0, ST_IGNORED);
    add_row(make_req(MODE_FREE, 16'd16, 20'h00100, 1'b1), 1, 20'd0, ST_IGNORED);
    add_row(make_req(MODE_FREE, 16'd700, 20'h00100, 1'b0), 1, 20'd0, ST_OVERSIZE);
    add_row(make_req(MODE_FREE, 16'hFFFF, 20'h00100, 1'b0), 1, 20'd0, ST_OVERSIZE);
    // unaligned free at the top of the address space
    add_row(make_req(MODE_FREE, 16'd640, 20'hFFFFF, 1'b0), 1, 20'd0, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd600, 20'h00000, 1'b0), 1, 20'hFFFF0, ST_DONE);
    add_row(make_req(MODE_FREE, 16'd100, 20'h12347, 1'b0), 1, 20'd0, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd128, 20'h00000, 1'b0), 1, 20'h12340, ST_DONE);
    add_row(make_req(MODE_UNUSED, 16'hFFFF, 20'hFFFFF, 1'b1), 1, 20'd0, ST_IGNORED);
    add_row(make_req(MODE_FREE, 16'd16, 20'h00000, 1'b0), 1, 20'd0, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd10, 20'h00000, 1'b0), 0, 20'd0, ST_DONE);
    add_row(make_req(MODE_CLEAR, 16'hFFFF, 20'hFFFFF, 1'b1), 1, 20'd0, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd640, 20'h00000, 1'b0), 1, 20'd0, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd16, 20'h00000, 1'b0), 1, 20'd16384, ST_DONE);
    add_row(make_req(MODE_FREE, 16'd1, 20'h00010, 1'b0), 1, 20'd0, ST_DONE);
    add_row(make_req(MODE_ALLOC, 16'd0, 20'hFFFFF, 1'b1), 1, 20'd0, ST_IGNORED);
    add_row(make_req(MODE_ALLOC, 16'd512, 20'h00000, 1'b0), 1, 20'd32768, ST_DONE);
  endfunction

  always @(posedge clk) begin : check
    rsp_t want;
    if (rst_n && out_valid) begin
      if (expected_grants.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected response: addr %h status %0d",
                   out_rsp.result_address, out_rsp.status);
        error_count++;
      end else begin
        want = expected_grants.pop_front();
        if (out_rsp.result_address !== want.result_address ||
            out_rsp.status !== want.status) begin
          if (error_count < MAX_REPORTS)
            $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                     want.result_address, want.status,
                     out_rsp.result_address, out_rsp.status);
          error_count++;
        end
      end
    end
    if ((rst_n && start && !busy) || (rst_n && out_valid)) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    rsp_t none;
    int fill_step;
    int tail;
    none = '0;
    start <= 1'b0;
    in_req <= '0;
    rst_n <= 1'b0;
    empty_lists();
    build_plan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      pace(1'b0);
      issue(plan[i].req, plan[i].typed, plan[i].want);
    end

    while (items_sent < 275) begin
      pace($urandom_range(99) == 0);
      issue(gen_mixed(), 1'b0, none);
    end

    // hold off until drained, then fill the pool from a cleared state
    pace(1'b1);
    issue(make_req(MODE_CLEAR, SIZE_W'($urandom_range(65535)),
                   ADDR_W'($urandom_range(1048575)), 1'($urandom_range(1))),
          1'b0, none);
    fill_step = 0;
    saw_exhausted = 1'b0;
    while (!saw_exhausted) begin
      pace(1'b0);
      issue(gen_fill(fill_step), 1'b0, none);
      fill_step++;
    end

    tail = 0;
    while (items_sent < ITEM_TARGET || tail < 60) begin
      pace($urandom_range(99) == 0);
      issue(gen_mixed(), 1'b0, none);
      tail++;
    end

    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_grants.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/scba_pkg.sv
rtl/size_class_block_allocator_core.sv
sim/size_class_block_allocator_core_test.sv
